@@ design/gf2rdf_pkg.sv @@
package gf2rdf_pkg;

  typedef struct packed {
    logic [63:0] row_bits;
    logic        last_row;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] dependency_mask;
    logic [5:0]  row_number;
  } out_item_t;

  localparam logic [1:0] STATUS_INDEP = 2'd0;
  localparam logic [1:0] STATUS_DEP   = 2'd1;
  localparam logic [1:0] STATUS_OVF   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_LOOK,
    S_XOR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic piv_rd;
    logic basis_rd;
    logic wr_en;
    logic clr;
  } store_ctl_t;

endpackage

@@ design/gf2rdf_lowbit.sv @@
module gf2rdf_lowbit #(
  parameter int W  = 64,
  parameter int PW = 6
) (
  input  logic [W-1:0]  vec,
  output logic [PW-1:0] pos,
  output logic          none
);

  always_comb begin
    pos = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (vec[i]) begin
        pos = PW'(i);
      end
    end
    none = ~|vec;
  end

endmodule

@@ design/gf2rdf_store.sv @@
module gf2rdf_store #(
  parameter int ROW_WIDTH = 64,
  parameter int MAX_ROWS  = 64,
  parameter int PW        = 6,
  parameter int IW        = 6
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  gf2rdf_pkg::store_ctl_t ctl,
  input  logic [PW-1:0]          piv_addr,
  input  logic [IW-1:0]          wr_idx,
  input  logic [ROW_WIDTH-1:0]   wr_row,
  input  logic [MAX_ROWS-1:0]    wr_tag,
  output logic                   piv_hit,
  output logic [ROW_WIDTH-1:0]   basis_q,
  output logic [MAX_ROWS-1:0]    tag_q
);

  logic [ROW_WIDTH-1:0] piv_valid_r;
  logic [IW-1:0]        piv_mem [ROW_WIDTH];
  logic [ROW_WIDTH-1:0] basis_mem [MAX_ROWS];
  logic [MAX_ROWS-1:0]  tag_mem [MAX_ROWS];
  logic [IW-1:0]        piv_q_r;
  logic                 piv_hit_r;
  logic [ROW_WIDTH-1:0] basis_q_r;
  logic [MAX_ROWS-1:0]  tag_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      piv_valid_r <= '0;
    end else if (ctl.wr_en) begin
      piv_valid_r[piv_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      piv_mem[piv_addr] <= wr_idx;
      basis_mem[wr_idx] <= wr_row;
      tag_mem[wr_idx]   <= wr_tag;
    end
    if (ctl.piv_rd) begin
      piv_q_r   <= piv_mem[piv_addr];
      piv_hit_r <= piv_valid_r[piv_addr];
    end
    if (ctl.basis_rd) begin
      basis_q_r <= basis_mem[piv_q_r];
      tag_q_r   <= tag_mem[piv_q_r];
    end
  end

  assign piv_hit = piv_hit_r;
  assign basis_q = basis_q_r;
  assign tag_q   = tag_q_r;

endmodule

@@ design/gf2_row_dependency_finder_unit.sv @@
// GF(2) row dependency finder. Rows of one matrix arrive one item at a time, the final one
// marked by last_row, after which the basis and row count clear. Each row is reduced against
// the stored basis by repeated XOR steps on one shared datapath; every step reads the pivot
// table and then the basis and tag memories, each through a registered RAM port. A row takes
// at most ROW_WIDTH XOR steps; an overflow row takes none. The next row can be taken in the
// same cycle in which the previous result is first offered. The input is stalled while a row
// is in work; a finished item may wait in the output register while the next row enters.
// Status is 0 for an independent row, 1 for a dependent row (the mask then lists the rows whose
// XOR is zero), 2 for a row beyond MAX_ROWS, which is rejected.
module gf2_row_dependency_finder_unit #(
  parameter int ROW_WIDTH = 64,
  parameter int MAX_ROWS  = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  gf2rdf_pkg::in_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output gf2rdf_pkg::out_item_t out_item
);

  localparam int PW = (ROW_WIDTH > 1) ? $clog2(ROW_WIDTH) : 1;
  localparam int IW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = $clog2(MAX_ROWS + 1);

  gf2rdf_pkg::state_t     state_r, state_nxt;
  logic [ROW_WIDTH-1:0]   row_r, row_nxt;
  logic [MAX_ROWS-1:0]    tag_r, tag_nxt;
  logic [IW-1:0]          num_r, num_nxt;
  logic                   last_r, last_nxt;
  logic [1:0]             status_r, status_nxt;
  logic [CW-1:0]          row_cnt_r, row_cnt_nxt;
  logic [CW-1:0]          basis_cnt_r, basis_cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  gf2rdf_pkg::out_item_t  out_item_r, out_item_nxt;

  gf2rdf_pkg::store_ctl_t ctl;
  logic [PW-1:0]          low_pos;
  logic                   row_zero;
  logic                   piv_hit;
  logic [ROW_WIDTH-1:0]   basis_q;
  logic [MAX_ROWS-1:0]    tag_q;
  logic                   ovf;
  logic                   out_load;

  gf2rdf_lowbit #(
    .W  (ROW_WIDTH),
    .PW (PW)
  ) u_lowbit (
    .vec  (row_r),
    .pos  (low_pos),
    .none (row_zero)
  );

  gf2rdf_store #(
    .ROW_WIDTH (ROW_WIDTH),
    .MAX_ROWS  (MAX_ROWS),
    .PW        (PW),
    .IW        (IW)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .piv_addr (low_pos),
    .wr_idx   (basis_cnt_r[IW-1:0]),
    .wr_row   (row_r),
    .wr_tag   (tag_r),
    .piv_hit  (piv_hit),
    .basis_q  (basis_q),
    .tag_q    (tag_q)
  );

  assign ovf = (row_cnt_r >= CW'(MAX_ROWS));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gf2rdf_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = ovf ? gf2rdf_pkg::S_DONE : gf2rdf_pkg::S_FIND;
        end
      end
      gf2rdf_pkg::S_FIND: begin
        state_nxt = row_zero ? gf2rdf_pkg::S_DONE : gf2rdf_pkg::S_LOOK;
      end
      gf2rdf_pkg::S_LOOK: begin
        state_nxt = piv_hit ? gf2rdf_pkg::S_XOR : gf2rdf_pkg::S_DONE;
      end
      gf2rdf_pkg::S_XOR: begin
        state_nxt = gf2rdf_pkg::S_FIND;
      end
      gf2rdf_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = gf2rdf_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = gf2rdf_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall     = (state_r != gf2rdf_pkg::S_IDLE);
    out_load     = (state_r == gf2rdf_pkg::S_DONE) && (!out_valid_r || !out_stall);
    ctl.piv_rd   = (state_r == gf2rdf_pkg::S_FIND);
    ctl.basis_rd = (state_r == gf2rdf_pkg::S_LOOK) && piv_hit;
    ctl.wr_en    = (state_r == gf2rdf_pkg::S_LOOK) && !piv_hit;
    ctl.clr      = out_load && last_r;
  end

  always_comb begin
    row_nxt       = row_r;
    tag_nxt       = tag_r;
    num_nxt       = num_r;
    last_nxt      = last_r;
    status_nxt    = status_r;
    row_cnt_nxt   = row_cnt_r;
    basis_cnt_nxt = basis_cnt_r;
    if ((state_r == gf2rdf_pkg::S_IDLE) && in_valid) begin
      row_nxt  = in_item.row_bits[ROW_WIDTH-1:0];
      last_nxt = in_item.last_row;
      if (ovf) begin
        status_nxt = gf2rdf_pkg::STATUS_OVF;
        num_nxt    = '0;
      end else begin
        status_nxt  = gf2rdf_pkg::STATUS_DEP;
        tag_nxt     = MAX_ROWS'(1) << row_cnt_r[IW-1:0];
        num_nxt     = row_cnt_r[IW-1:0];
        row_cnt_nxt = row_cnt_r + CW'(1);
      end
    end
    if (ctl.wr_en) begin
      status_nxt    = gf2rdf_pkg::STATUS_INDEP;
      basis_cnt_nxt = basis_cnt_r + CW'(1);
    end
    if (state_r == gf2rdf_pkg::S_XOR) begin
      row_nxt = row_r ^ basis_q;
      tag_nxt = tag_r ^ tag_q;
    end
    if (ctl.clr) begin
      row_cnt_nxt   = '0;
      basis_cnt_nxt = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_load || (out_valid_r && out_stall);
    out_item_nxt  = out_item_r;
    if (out_load) begin
      out_item_nxt.status          = status_r;
      out_item_nxt.dependency_mask = (status_r == gf2rdf_pkg::STATUS_DEP) ? 64'(tag_r) : '0;
      out_item_nxt.row_number      = 6'(num_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gf2rdf_pkg::S_IDLE;
      row_cnt_r   <= '0;
      basis_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_cnt_r   <= row_cnt_nxt;
      basis_cnt_r <= basis_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    tag_r      <= tag_nxt;
    num_r      <= num_nxt;
    last_r     <= last_nxt;
    status_r   <= status_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ design/gf2rdf_checker.sv @@
module gf2rdf_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input gf2rdf_pkg::out_item_t out_item
);

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status == gf2rdf_pkg::STATUS_INDEP ||
                   out_item.status == gf2rdf_pkg::STATUS_DEP ||
                   out_item.status == gf2rdf_pkg::STATUS_OVF))
    else $error("result status out of range");

  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == gf2rdf_pkg::STATUS_OVF
      |-> out_item.dependency_mask == '0 && out_item.row_number == '0)
    else $error("rejected row carries mask or row number");

  a_indep_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == gf2rdf_pkg::STATUS_INDEP
      |-> out_item.dependency_mask == '0)
    else $error("independent row carries a mask");

  a_dep_self: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == gf2rdf_pkg::STATUS_DEP
      |-> out_item.dependency_mask[out_item.row_number])
    else $error("dependent row mask misses its own row");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled item changed or dropped");

endmodule

bind gf2_row_dependency_finder_unit gf2rdf_checker u_gf2rdf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
